### sv/sqd_pkg.sv
// ----------------------------------------------------------------------------
// sqd_pkg: shared constants, types and helpers for the int8 squared distance
// block.
// ----------------------------------------------------------------------------
package sqd_pkg;

  // Longest vector the block handles, and the widths that follow from it.
  localparam int MAX_ELEMENTS = 4096;
  localparam int LEN_W        = 13;
  localparam int POS_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int SUM_W        = 28;
  localparam int MSB_W        = $clog2(SUM_W);
  localparam int MANT_W       = 24;
  localparam int WORD_W       = 32;

  // Mode codes. The unused code behaves as stored-stored.
  localparam logic [1:0] MODE_SS   = 2'd0;
  localparam logic [1:0] MODE_SQ   = 2'd1;
  localparam logic [1:0] MODE_PREP = 2'd2;

  localparam logic [7:0] SIGN_FLIP = 8'h80;
  localparam logic [7:0] EXP_BIAS  = 8'd127;

  // One request passed from the accumulator to the float converter.
  typedef struct packed {
    logic [7:0]              flipped;
    logic                    done;
    logic                    prep;
    logic [SUM_W-1:0]        dsum;
    logic signed [SUM_W-1:0] corr;
  } sqd_acc_t;

  // Vector length as used: zero counts as one, large values saturate.
  function automatic logic [POS_W-1:0] sqd_eff_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] n;
    n = len;
    if (n == '0) begin
      n = LEN_W'(1);
    end
    if (n > LEN_W'(MAX_ELEMENTS)) begin
      n = LEN_W'(MAX_ELEMENTS);
    end
    return POS_W'(n);
  endfunction

endpackage

### sv/sqd_accum.sv
// ----------------------------------------------------------------------------
// sqd_accum: input register and per-element multiply-accumulate
// Latches the mode at the first element, accumulates the squared difference
// or the preprocess correction, and hands on the requests that make results.
// ----------------------------------------------------------------------------
module sqd_accum import sqd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [LEN_W-1:0]    vector_length,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_mode,
  input  logic signed [7:0]   in_stored_byte,
  input  logic [7:0]          in_other_byte,
  output logic                acc_valid,
  output sqd_acc_t            acc,
  input  logic                acc_ready
);

  logic                    s0_valid_r;
  logic [1:0]              s0_mode_r;
  logic signed [7:0]       s0_stored_r;
  logic [7:0]              s0_other_r;
  logic [1:0]              held_mode_r;
  logic [POS_W-1:0]        pos_r;
  logic [SUM_W-1:0]        dist_sum_r;
  logic signed [SUM_W-1:0] corr_sum_r;
  logic                    acc_valid_r;
  sqd_acc_t                acc_r;

  logic                    first;
  logic [1:0]              cur_mode;
  logic                    prep;
  logic                    query;
  logic [7:0]              flip;
  logic signed [7:0]       other_s;
  logic signed [8:0]       diff;
  logic signed [17:0]      dist_sq;
  logic signed [9:0]       v_ext;
  logic signed [9:0]       v_m;
  logic signed [19:0]      corr_term;
  logic [SUM_W-1:0]        dist_base;
  logic signed [SUM_W-1:0] corr_base;
  logic [SUM_W-1:0]        dist_nxt;
  logic signed [SUM_W-1:0] corr_nxt;
  logic [POS_W-1:0]        pos_inc;
  logic                    done;
  logic                    emit;
  logic                    s0_adv;
  sqd_acc_t                acc_nxt;

  // Per-element arithmetic on the registered request.
  always_comb begin
    first     = (pos_r == '0);
    cur_mode  = first ? s0_mode_r : held_mode_r;
    prep      = (cur_mode == MODE_PREP);
    query     = (cur_mode == MODE_SQ);
    flip      = s0_other_r ^ SIGN_FLIP;
    // A shifted query byte minus 128 is the same byte with its top bit flipped.
    other_s   = query ? signed'(flip) : signed'(s0_other_r);
    diff      = {s0_stored_r[7], s0_stored_r} - {other_s[7], other_s};
    dist_sq   = diff * diff;
    v_ext     = {2'b00, flip};
    v_m       = v_ext - 10'sd256;
    corr_term = v_ext * v_m;
    dist_base = first ? '0 : dist_sum_r;
    corr_base = first ? '0 : corr_sum_r;
    dist_nxt  = prep ? dist_base : dist_base + SUM_W'(dist_sq[15:0]);
    corr_nxt  = prep ? corr_base + {{(SUM_W-20){corr_term[19]}}, corr_term} : corr_base;
    pos_inc   = pos_r + POS_W'(1);
    done      = (pos_inc >= sqd_eff_len(vector_length));
    emit      = done || prep;
    s0_adv    = s0_valid_r && (!emit || !acc_valid_r || acc_ready);
    in_stall  = s0_valid_r && !s0_adv;

    acc_nxt.flipped = prep ? flip : 8'd0;
    acc_nxt.done    = done;
    acc_nxt.prep    = prep;
    acc_nxt.dsum    = dist_nxt;
    acc_nxt.corr    = corr_nxt;
  end

  // Control state and accumulators.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      held_mode_r <= MODE_SS;
      pos_r       <= '0;
      dist_sum_r  <= '0;
      corr_sum_r  <= '0;
      acc_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s0_valid_r <= in_valid;
      end
      if (s0_adv) begin
        held_mode_r <= cur_mode;
        pos_r       <= done ? '0 : pos_inc;
        dist_sum_r  <= dist_nxt;
        corr_sum_r  <= corr_nxt;
      end
      if (s0_adv && emit) begin
        acc_valid_r <= 1'b1;
      end else if (acc_ready) begin
        acc_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s0_mode_r   <= in_mode;
      s0_stored_r <= in_stored_byte;
      s0_other_r  <= in_other_byte;
    end
    if (s0_adv && emit) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc_valid = acc_valid_r;
  assign acc       = acc_r;

endmodule

### sv/sqd_float.sv
// ----------------------------------------------------------------------------
// sqd_float: sum to IEEE single conversion and result register
// One stage finds the leading one, the next normalizes and rounds to nearest
// even and loads the result register.
// ----------------------------------------------------------------------------
module sqd_float import sqd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     acc_valid,
  input  sqd_acc_t                 acc,
  output logic                     acc_ready,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [7:0]               out_flipped_byte,
  output logic [WORD_W-1:0]        out_distance_bits,
  output logic signed [WORD_W-1:0] out_correction,
  output logic                     out_correction_ok,
  output logic                     out_vector_done
);

  logic                     a_valid_r;
  sqd_acc_t                 a_r;
  logic [MSB_W-1:0]         a_msb_r;
  logic                     out_valid_r;
  logic [7:0]               flipped_r;
  logic [WORD_W-1:0]        dist_bits_r;
  logic signed [WORD_W-1:0] corr_r;
  logic                     corr_ok_r;
  logic                     done_r;

  logic [MSB_W-1:0]         msb;
  logic                     out_ready;
  logic [MSB_W-1:0]         shamt;
  logic [SUM_W-1:0]         norm;
  logic                     rnd;
  logic [MANT_W:0]          mant;
  logic                     carry;
  logic [7:0]               exp_f;
  logic [MANT_W-2:0]        frac;
  logic [WORD_W-1:0]        bits;

  // Leading-one position of the distance sum.
  always_comb begin
    msb = '0;
    for (int i = 0; i < SUM_W; i++) begin
      if (acc.dsum[i]) begin
        msb = MSB_W'(i);
      end
    end
  end

  assign out_ready = !out_valid_r || !out_stall;
  assign acc_ready = !a_valid_r || out_ready;

  // Normalize, round to nearest even, and pack the single.
  always_comb begin
    shamt = MSB_W'(SUM_W - 1) - a_msb_r;
    norm  = a_r.dsum << shamt;
    rnd   = norm[SUM_W-MANT_W-1] &&
            ((|norm[SUM_W-MANT_W-2:0]) || norm[SUM_W-MANT_W]);
    mant  = {1'b0, norm[SUM_W-1 -: MANT_W]} + (MANT_W+1)'(rnd);
    carry = mant[MANT_W];
    exp_f = EXP_BIAS + 8'(a_msb_r) + 8'(carry);
    frac  = carry ? '0 : mant[MANT_W-2:0];
    bits  = (a_r.dsum == '0) ? '0 : {1'b0, exp_f, frac};
  end

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc_ready) begin
        a_valid_r <= acc_valid;
      end
      if (out_ready) begin
        out_valid_r <= a_valid_r;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (acc_ready && acc_valid) begin
      a_r     <= acc;
      a_msb_r <= msb;
    end
    if (out_ready && a_valid_r) begin
      flipped_r   <= a_r.flipped;
      done_r      <= a_r.done;
      dist_bits_r <= (a_r.done && !a_r.prep) ? bits : '0;
      corr_r      <= (a_r.done && a_r.prep) ?
                     {{(WORD_W-SUM_W){a_r.corr[SUM_W-1]}}, a_r.corr} : '0;
      corr_ok_r   <= a_r.done && a_r.prep;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_flipped_byte  = flipped_r;
  assign out_distance_bits = dist_bits_r;
  assign out_correction    = corr_r;
  assign out_correction_ok = corr_ok_r;
  assign out_vector_done   = done_r;

endmodule

### sv/quantized_int8_squared_distance.sv
// ----------------------------------------------------------------------------
// quantized_int8_squared_distance: streaming int8 squared distance unit
// The block takes one element pair per cycle unless it stalls, and closes a
// vector after vector_length elements (zero counts as one, values above 4096
// count as 4096). Stored-stored and stored-query modes give one result per
// vector: the squared distance as an IEEE single rounded to nearest even.
// Preprocess mode gives one result per element with the flipped query byte,
// and the closing one also carries the correction sum and its valid flag.
// A request taken into the input register passes the multiply-accumulate,
// the leading-one search, then normalize and round into the result register;
// the rate is one element per cycle while in_stall is low. Each stage has its
// own valid and holds while the next is full, so elements that make no result
// keep flowing while a result waits.
// Write vector_length only while idle.
// ----------------------------------------------------------------------------
module quantized_int8_squared_distance import sqd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [LEN_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_mode,
  input  logic signed [7:0]        in_stored_byte,
  input  logic [7:0]               in_other_byte,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [7:0]               out_flipped_byte,
  output logic [WORD_W-1:0]        out_distance_bits,
  output logic signed [WORD_W-1:0] out_correction,
  output logic                     out_correction_ok,
  output logic                     out_vector_done
);

  logic [LEN_W-1:0] vector_length_r;
  logic             acc_valid;
  sqd_acc_t         acc;
  logic             acc_ready;

  // Vector length register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vector_length_r <= LEN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      vector_length_r <= cfg_data;
    end
  end

  sqd_accum u_accum (
    .clk            (clk),
    .rst_n          (rst_n),
    .vector_length  (vector_length_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_stored_byte (in_stored_byte),
    .in_other_byte  (in_other_byte),
    .acc_valid      (acc_valid),
    .acc            (acc),
    .acc_ready      (acc_ready)
  );

  sqd_float u_float (
    .clk               (clk),
    .rst_n             (rst_n),
    .acc_valid         (acc_valid),
    .acc               (acc),
    .acc_ready         (acc_ready),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_flipped_byte  (out_flipped_byte),
    .out_distance_bits (out_distance_bits),
    .out_correction    (out_correction),
    .out_correction_ok (out_correction_ok),
    .out_vector_done   (out_vector_done)
  );

  // The correction flag only rides on a closing result.
  a_ok_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_correction_ok |-> out_vector_done)
    else $error("correction flag on a result that does not close a vector");

  // Results inside a vector carry no distance and no correction.
  a_mid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_vector_done |-> out_distance_bits == '0 && out_correction == '0)
    else $error("mid-vector result carries a sum");

  // A nonzero distance has an exponent within the range of the sum width.
  a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_distance_bits != '0 |->
      out_distance_bits[30:23] >= EXP_BIAS &&
      out_distance_bits[30:23] <= EXP_BIAS + 8'(SUM_W))
    else $error("distance exponent out of range");

  // A request waiting between accumulator and converter is not lost.
  a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    acc_valid && !acc_ready |=> acc_valid)
    else $error("accumulator request dropped while converter was busy");

endmodule
